// ----- sv/fmfc_pkg.sv -----
// shared types, constants and helper functions for the five-mode fluid chaos stepper
`default_nettype none

package fmfc_pkg;

    localparam int DATA_W      = 32;
    localparam int FRAC_W      = 20;
    localparam int STEP_W      = 21;
    localparam int ACC_W       = 48;
    localparam int PROD_W      = 2 * DATA_W;
    localparam int Q_W         = PROD_W - FRAC_W;
    localparam int INC_W       = 34;
    localparam int SUM_W       = INC_W + 1;
    localparam int NUM_MODES   = 5;
    localparam int NUM_PRODS   = 6;
    localparam int IDX_W       = 3;
    localparam int CNT_W       = 3;
    localparam int CMD_W       = 2;
    localparam int VIDX_W      = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 168;

    localparam logic signed [DATA_W-1:0] ONE_Q        = 32'sd1048576;
    localparam logic signed [DATA_W-1:0] REYNOLDS_RST = 32'sd29360128;
    localparam logic [STEP_W-1:0]        STEP_RST     = 21'd10486;
    localparam logic signed [DATA_W-1:0] S32_MAX      = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] S32_MIN      = 32'sh8000_0000;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK    = 2'd0,
        CMD_RESTORE = 2'd1,
        CMD_WRITE   = 2'd2,
        CMD_UNUSED  = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_REYNOLDS      = 3'd0,
        REG_STEP_SIZE     = 3'd1,
        REG_INIT_X1       = 3'd2,
        REG_INIT_X2       = 3'd3,
        REG_INIT_X3       = 3'd4,
        REG_INIT_X4       = 3'd5,
        REG_INIT_X5       = 3'd6,
        REG_EMIT_ON_WRITE = 3'd7
    } cfg_reg_t;

    typedef enum logic [2:0] {
        COEF_P4 = 3'd0,
        COEF_P3 = 3'd1,
        COEF_M7 = 3'd2,
        COEF_M1 = 3'd3,
        COEF_M3 = 3'd4
    } coef_t;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_INIT  = 5'b00010,
        ST_PROD  = 5'b00100,
        ST_SCALE = 5'b01000,
        ST_HOLD  = 5'b10000
    } state_t;

    // sequencer to datapath control
    typedef struct packed {
        logic             idle;
        logic             init;
        logic             prod_issue;
        logic [CNT_W-1:0] prod_idx;
        logic             prod_acc;
        logic [CNT_W-1:0] acc_idx;
        logic             scale_issue;
        logic [IDX_W-1:0] scale_idx;
        logic             scale_upd;
        logic [IDX_W-1:0] upd_idx;
        logic             publish;
    } ctrl_t;

    typedef struct packed {
        logic              clipped;
        logic [DATA_W-1:0] val;
    } clip_t;

    // derivative that each cross product feeds
    function automatic logic [IDX_W-1:0] prod_dest(input logic [CNT_W-1:0] k);
        logic [IDX_W-1:0] d;
        case (k)
            3'd0, 3'd1: d = 3'd0;
            3'd2:       d = 3'd1;
            3'd3:       d = 3'd2;
            3'd4:       d = 3'd3;
            3'd5:       d = 3'd4;
            default:    d = 3'd0;
        endcase
        return d;
    endfunction

    function automatic coef_t prod_coef(input logic [CNT_W-1:0] k);
        coef_t c;
        case (k)
            3'd0, 3'd1: c = COEF_P4;
            3'd2:       c = COEF_P3;
            3'd3:       c = COEF_M7;
            3'd4:       c = COEF_M1;
            3'd5:       c = COEF_M3;
            default:    c = COEF_P4;
        endcase
        return c;
    endfunction

    // small constant weight by shift and add
    function automatic logic signed [ACC_W-1:0] apply_coef(
        input logic signed [ACC_W-1:0] q,
        input coef_t                   c
    );
        logic signed [ACC_W-1:0] r;
        case (c)
            COEF_P4: r = q <<< 2;
            COEF_P3: r = q + (q <<< 1);
            COEF_M7: r = q - (q <<< 3);
            COEF_M1: r = -q;
            COEF_M3: r = -(q + (q <<< 1));
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic clip_t clip_acc(input logic signed [ACC_W-1:0] v);
        clip_t r;
        logic  over;
        over      = !((&v[ACC_W-1:DATA_W-1]) || !(|v[ACC_W-1:DATA_W-1]));
        r.clipped = over;
        r.val     = over ? (v[ACC_W-1] ? S32_MIN : S32_MAX) : v[DATA_W-1:0];
        return r;
    endfunction

    function automatic clip_t clip_sum(input logic signed [SUM_W-1:0] v);
        clip_t r;
        logic  over;
        over      = !((&v[SUM_W-1:DATA_W-1]) || !(|v[SUM_W-1:DATA_W-1]));
        r.clipped = over;
        r.val     = over ? (v[SUM_W-1] ? S32_MIN : S32_MAX) : v[DATA_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- sv/fmfc_mul.sv -----
// shared signed 32x32 multiplier with registered product
`default_nettype none

module fmfc_mul
    import fmfc_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic signed [DATA_W-1:0] op_a,
    input  wire logic signed [DATA_W-1:0] op_b,
    output logic signed [PROD_W-1:0]      prod
);

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// ----- sv/fmfc_seq.sv -----
// step sequencer: cross products, then per-mode scale and update
`default_nettype none

module fmfc_seq
    import fmfc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire logic out_busy,
    output ctrl_t     ctrl
);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ctrl       = '0;
        case (state_reg)
            ST_IDLE:
            begin
                ctrl.idle = 1'b1;
                if (start)
                begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                ctrl.init  = 1'b1;
                state_next = ST_PROD;
                cnt_next   = '0;
            end
            ST_PROD:
            begin
                // issue product k while folding in product k-1
                ctrl.prod_issue = (cnt_reg < CNT_W'(NUM_PRODS));
                ctrl.prod_idx   = cnt_reg;
                ctrl.prod_acc   = (cnt_reg != '0);
                ctrl.acc_idx    = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(NUM_PRODS))
                begin
                    state_next = ST_SCALE;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_SCALE:
            begin
                ctrl.scale_issue = (cnt_reg < CNT_W'(NUM_MODES));
                ctrl.scale_idx   = IDX_W'(cnt_reg);
                ctrl.scale_upd   = (cnt_reg != '0);
                ctrl.upd_idx     = IDX_W'(cnt_reg - CNT_W'(1));
                if (cnt_reg == CNT_W'(NUM_MODES))
                begin
                    state_next = ST_HOLD;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_HOLD:
            begin
                ctrl.publish = !out_busy;
                if (!out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/five_mode_fluid_chaos_stepper_unit.sv -----
// top level: five-mode truncated navier-stokes chaos generator, q12.20
`default_nettype none

// Five-mode truncated 2-D Navier-Stokes chaos generator in signed Q12.20.
// A tick beat (cmd 0) emits the five current modes and then advances them
// by one forward Euler step of size step_size with reynolds as drive; the
// saturated bit of the result says whether any derivative or new mode was
// clipped to the 32 bit range. cmd 1 reloads the modes from init_x1..x5 and
// cmd 2 loads mode var_index (0 to 4) from value; a write also emits and
// steps when emit_on_write is set. Restore, plain writes and cmd 3 give no
// result. A stepping beat snapshots the modes, pushes the six cross
// products through the single shared 32x32 multiplier and folds them into
// the derivatives, scales each clipped derivative by dt on the same
// multiplier and writes the mode back, and then loads the result register.
// s_axis_tready stays low while a step is in flight; a finished result
// waits in its own register, so the next beat is accepted while it is
// unread, and the following step holds at its end until that register
// frees. Configuration is written through cfg_wr_en/cfg_index/cfg_data and
// must only be written while the block is idle.
module five_mode_fluid_chaos_stepper_unit
    import fmfc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // cfg port
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [DATA_W-1:0]      cfg_data,
    // command beats
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // cmd [1:0], var_index [4:2], value [36:5], zero pad [39:37]
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // result beats
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // out_x1 [31:0], out_x2 [63:32], out_x3 [95:64], out_x4 [127:96],
    // out_x5 [159:128], saturated [160], zero pad [167:161]
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

    // configuration registers
    logic signed [DATA_W-1:0] reynolds_reg;
    logic [STEP_W-1:0]        step_size_reg;
    logic signed [DATA_W-1:0] init_reg [NUM_MODES];
    logic                     emit_on_write_reg;

    // state and working registers
    logic signed [DATA_W-1:0] mode_reg  [NUM_MODES];
    logic signed [DATA_W-1:0] mode_next [NUM_MODES];
    logic signed [DATA_W-1:0] snap_reg  [NUM_MODES];
    logic signed [ACC_W-1:0]  acc_reg   [NUM_MODES];
    logic                     sat_reg, sat_next;
    logic                     m_valid_reg;
    logic [OUT_TDATA_W-1:0]   m_data_reg;

    // input beat fields
    cmd_t                     in_cmd;
    logic [VIDX_W-1:0]        in_var_index;
    logic signed [DATA_W-1:0] in_value;
    logic                     accept;
    logic                     start;
    logic                     out_busy;

    ctrl_t                    ctrl;

    // shared multiplier
    logic                     mul_en;
    logic signed [DATA_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;

    // datapath nets
    logic [IDX_W-1:0]         acc_rd_idx;
    logic signed [ACC_W-1:0]  acc_rd;
    logic signed [Q_W-1:0]    prod_q;
    logic signed [ACC_W-1:0]  prod_term;
    clip_t                    der_clip;
    logic signed [INC_W-1:0]  inc;
    logic signed [SUM_W-1:0]  upd_sum;
    clip_t                    sum_clip;
    logic signed [ACC_W-1:0]  lin_a, lin_b, lin_c, lin_d, lin_e, lin_r;

    assign in_cmd       = cmd_t'(s_axis_tdata[CMD_W-1:0]);
    assign in_var_index = s_axis_tdata[CMD_W+VIDX_W-1:CMD_W];
    assign in_value     = s_axis_tdata[CMD_W+VIDX_W+DATA_W-1:CMD_W+VIDX_W];

    assign s_axis_tready = ctrl.idle;
    assign accept        = s_axis_tvalid && s_axis_tready;
    // a step follows a tick, or a write when emit-on-write is set
    assign start         = accept && ((in_cmd == CMD_TICK) ||
                                      ((in_cmd == CMD_WRITE) && emit_on_write_reg));
    assign out_busy      = m_valid_reg && !m_axis_tready;

    fmfc_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .out_busy (out_busy),
        .ctrl     (ctrl)
    );

    // operand select: cross products first, then derivative times dt
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (ctrl.scale_issue)
        begin
            mul_a = signed'(der_clip.val);
            mul_b = signed'({{(DATA_W-STEP_W){1'b0}}, step_size_reg});
        end
        else
        begin
            case (ctrl.prod_idx)
                3'd0:    begin mul_a = mode_reg[1]; mul_b = mode_reg[2]; end
                3'd1:    begin mul_a = mode_reg[3]; mul_b = mode_reg[4]; end
                3'd2:    begin mul_a = mode_reg[0]; mul_b = mode_reg[2]; end
                3'd3:    begin mul_a = mode_reg[0]; mul_b = mode_reg[1]; end
                3'd4:    begin mul_a = mode_reg[0]; mul_b = mode_reg[4]; end
                3'd5:    begin mul_a = mode_reg[0]; mul_b = mode_reg[3]; end
                default: begin mul_a = '0;          mul_b = '0;          end
            endcase
        end
    end

    assign mul_en = ctrl.prod_issue || ctrl.scale_issue;

    fmfc_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_p)
    );

    // one read port on the derivative accumulators
    assign acc_rd_idx = ctrl.scale_issue ? ctrl.scale_idx : prod_dest(ctrl.acc_idx);
    assign acc_rd     = acc_reg[acc_rd_idx];
    assign der_clip   = clip_acc(acc_rd);

    // floor shift of the cross product, then its weight
    assign prod_q    = mul_p[PROD_W-1:FRAC_W];
    assign prod_term = apply_coef(ACC_W'(prod_q), prod_coef(ctrl.acc_idx));

    // euler update of one mode
    assign inc      = mul_p[FRAC_W+INC_W-1:FRAC_W];
    assign upd_sum  = SUM_W'(mode_reg[ctrl.upd_idx]) + SUM_W'(inc);
    assign sum_clip = clip_sum(upd_sum);

    // linear terms seed the accumulators
    assign lin_a = ACC_W'(mode_reg[0]);
    assign lin_b = ACC_W'(mode_reg[1]);
    assign lin_c = ACC_W'(mode_reg[2]);
    assign lin_d = ACC_W'(mode_reg[3]);
    assign lin_e = ACC_W'(mode_reg[4]);
    assign lin_r = ACC_W'(reynolds_reg);

    always_ff @(posedge clk)
    begin
        if (ctrl.init)
        begin
            acc_reg[0] <= -(lin_a <<< 1);
            acc_reg[1] <= -((lin_b <<< 3) + lin_b);
            acc_reg[2] <= lin_r - ((lin_c <<< 2) + lin_c);
            acc_reg[3] <= -((lin_d <<< 2) + lin_d);
            acc_reg[4] <= -lin_e;
            for (int i = 0; i < NUM_MODES; i++)
            begin
                snap_reg[i] <= mode_reg[i];
            end
        end
        else if (ctrl.prod_acc)
        begin
            acc_reg[acc_rd_idx] <= acc_rd + prod_term;
        end
    end

    // mode state: restore, write, euler write-back
    always_comb
    begin
        for (int i = 0; i < NUM_MODES; i++)
        begin
            mode_next[i] = mode_reg[i];
        end
        if (accept && (in_cmd == CMD_RESTORE))
        begin
            for (int i = 0; i < NUM_MODES; i++)
            begin
                mode_next[i] = init_reg[i];
            end
        end
        else if (accept && (in_cmd == CMD_WRITE) && (in_var_index < VIDX_W'(NUM_MODES)))
        begin
            mode_next[in_var_index] = in_value;
        end
        if (ctrl.scale_upd)
        begin
            mode_next[ctrl.upd_idx] = signed'(sum_clip.val);
        end
    end

    always_comb
    begin
        sat_next = sat_reg;
        if (ctrl.init)
        begin
            sat_next = 1'b0;
        end
        if (ctrl.scale_issue && der_clip.clipped)
        begin
            sat_next = 1'b1;
        end
        if (ctrl.scale_upd && sum_clip.clipped)
        begin
            sat_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_MODES; i++)
            begin
                mode_reg[i] <= ONE_Q;
            end
            sat_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < NUM_MODES; i++)
            begin
                mode_reg[i] <= mode_next[i];
            end
            sat_reg <= sat_next;
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reynolds_reg      <= REYNOLDS_RST;
            step_size_reg     <= STEP_RST;
            emit_on_write_reg <= 1'b0;
            for (int i = 0; i < NUM_MODES; i++)
            begin
                init_reg[i] <= ONE_Q;
            end
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index inside {[REG_INIT_X1:REG_INIT_X5]})
            begin
                init_reg[IDX_W'(cfg_index - REG_INIT_X1)] <= signed'(cfg_data);
            end
            else
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_REYNOLDS:      reynolds_reg      <= signed'(cfg_data);
                    REG_STEP_SIZE:     step_size_reg     <= cfg_data[STEP_W-1:0];
                    REG_EMIT_ON_WRITE: emit_on_write_reg <= cfg_data[0];
                    default:           ;
                endcase
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (ctrl.publish)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.publish)
        begin
            m_data_reg <= {{(OUT_TDATA_W-NUM_MODES*DATA_W-1){1'b0}}, sat_reg,
                           snap_reg[4], snap_reg[3], snap_reg[2], snap_reg[1], snap_reg[0]};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // a finished step never overwrites an unread result
    a_publish_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.publish |-> !out_busy)
        else $error("result published over a pending beat");

    // a stepping beat keeps the input closed on the next cycle
    a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> !s_axis_tready)
        else $error("input reopened during a step");

    // the multiplier serves one phase at a time
    a_mul_phase: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctrl.prod_issue && ctrl.scale_issue))
        else $error("product and scale issued together");

    // result valid only rises after a publish
    a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(ctrl.publish))
        else $error("result valid without a finished step");

endmodule

`default_nettype wire

// ----- tb/sv/fmfc_tb_pkg.sv -----
// result prediction and checking for the five-mode fluid chaos stepper testbench
package fmfc_tb_pkg;

    import fmfc_pkg::*;

    // one result beat: the five modes before the step and the clip flag
    typedef struct packed {
        logic                               sat;
        logic [NUM_MODES-1:0][DATA_W-1:0]   modes;
    } mode_frame_t;

    class stepper_scoreboard;

        longint      reynolds;
        longint      dt;
        longint      init_q [NUM_MODES];
        longint      mode_q [NUM_MODES];
        bit          emit_on_write;
        bit          clipped;
        mode_frame_t pending_frames [$];
        int          failures;

        function new();
            reynolds      = longint'(REYNOLDS_RST);
            dt            = longint'(STEP_RST);
            emit_on_write = 1'b0;
            clipped       = 1'b0;
            failures      = 0;
            foreach (mode_q[i])
            begin
                init_q[i] = longint'(ONE_Q);
                mode_q[i] = longint'(ONE_Q);
            end
        endfunction

        function int outstanding();
            return pending_frames.size();
        endfunction

        function void note_failure(string what);
            failures++;
            if (failures <= 10)
                $display("mismatch: %s", what);
        endfunction

        function longint saturate(longint v);
            if (v > longint'(S32_MAX))
            begin
                clipped = 1'b1;
                return longint'(S32_MAX);
            end
            if (v < longint'(S32_MIN))
            begin
                clipped = 1'b1;
                return longint'(S32_MIN);
            end
            return v;
        endfunction

        // product of two modes, floored back to q12.20
        function longint qprod(longint p, longint q);
            return (p * q) >>> FRAC_W;
        endfunction

        // one forward euler step of the five-mode system
        function void euler_advance();
            longint a, b, c, d, e;
            longint rate [NUM_MODES];
            longint inc;
            a = mode_q[0];
            b = mode_q[1];
            c = mode_q[2];
            d = mode_q[3];
            e = mode_q[4];
            rate[0] = -2 * a + 4 * qprod(b, c) + 4 * qprod(d, e);
            rate[1] = -9 * b + 3 * qprod(a, c);
            rate[2] = -5 * c - 7 * qprod(a, b) + reynolds;
            rate[3] = -5 * d - qprod(a, e);
            rate[4] = -3 * qprod(a, d) - e;
            for (int i = 0; i < NUM_MODES; i++)
            begin
                inc       = (saturate(rate[i]) * dt) >>> FRAC_W;
                mode_q[i] = saturate(mode_q[i] + inc);
            end
        endfunction

        function void emit_and_advance();
            mode_frame_t f;
            for (int i = 0; i < NUM_MODES; i++)
                f.modes[i] = mode_q[i][DATA_W-1:0];
            clipped = 1'b0;
            euler_advance();
            f.sat = clipped;
            pending_frames.push_back(f);
        endfunction

        function void set_reg(cfg_reg_t r, logic [DATA_W-1:0] d);
            case (r)
                REG_REYNOLDS:      reynolds = longint'(signed'(d));
                REG_STEP_SIZE:     dt = longint'(d[STEP_W-1:0]);
                REG_EMIT_ON_WRITE: emit_on_write = d[0];
                default:           init_q[int'(r) - int'(REG_INIT_X1)] = longint'(signed'(d));
            endcase
        endfunction

        function void note_beat(cmd_t cmd, logic [VIDX_W-1:0] idx, logic [DATA_W-1:0] value);
            case (cmd)
                CMD_TICK:
                begin
                    emit_and_advance();
                end
                CMD_RESTORE:
                begin
                    mode_q = init_q;
                end
                CMD_WRITE:
                begin
                    if (idx < NUM_MODES)
                        mode_q[idx] = longint'(signed'(value));
                    if (emit_on_write)
                        emit_and_advance();
                end
                default:
                begin
                end
            endcase
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] beat);
            mode_frame_t       want;
            logic [DATA_W-1:0] got;
            if (pending_frames.size() == 0)
            begin
                note_failure($sformatf("result beat with nothing pending: %h", beat));
                return;
            end
            want = pending_frames.pop_front();
            for (int i = 0; i < NUM_MODES; i++)
            begin
                got = beat[i*DATA_W +: DATA_W];
                if (got !== want.modes[i])
                    note_failure($sformatf("out_x%0d expected %h got %h",
                                           i + 1, want.modes[i], got));
            end
            if (beat[NUM_MODES*DATA_W] !== want.sat)
                note_failure($sformatf("saturated expected %b got %b",
                                       want.sat, beat[NUM_MODES*DATA_W]));
        endfunction

    endclass

endpackage

// ----- tb/sv/testbench.sv -----
// top-level testbench for the five-mode fluid chaos stepper unit
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import fmfc_pkg::*;
    import fmfc_tb_pkg::*;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [DATA_W-1:0]      cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // cmd [1:0], var_index [4:2], value [36:5], zero pad [39:37]
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // out_x1 [31:0] .. out_x5 [159:128], saturated [160], zero pad [167:161]
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // gap switches, changed per phase so some stretches run without idling
    bit tx_gaps;
    bit rx_gaps;

    stepper_scoreboard sb;

    five_mode_fluid_chaos_stepper_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // idle length: mostly none or short, now and then a long one
    function automatic int gap_len(bit enabled);
        int r;
        if (!enabled)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // mode value: mostly near the attractor, sometimes anywhere or at the rails
    function automatic logic [DATA_W-1:0] pick_mode_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return int'($urandom_range(0, 8 << FRAC_W)) - (4 << FRAC_W);
        if (r < 80)
            return int'($urandom_range(0, 128 << FRAC_W)) - (64 << FRAC_W);
        if (r < 90)
            return $urandom;
        case ($urandom_range(0, 3))
            0:       return S32_MAX;
            1:       return S32_MIN;
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    // one command beat; valid stays up afterwards unless a gap follows
    task automatic send_beat(cmd_t cmd, logic [VIDX_W-1:0] idx, logic [DATA_W-1:0] value);
        int gap;
        gap = gap_len(tx_gaps);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - CMD_W - VIDX_W - DATA_W){1'b0}}, value, idx, cmd};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_beat(cmd, idx, value);
    endtask

    task automatic write_reg(cfg_reg_t r, logic [DATA_W-1:0] d);
        cfg_wr_en <= 1'b1;
        cfg_index <= r;
        cfg_data  <= d;
        @(posedge clk);
        sb.set_reg(r, d);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // drain every pending result, then let any trailing no-result beat finish
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (24) @(posedge clk);
    endtask

    // fresh settings for a random phase; unused upper data bits get noise
    task automatic random_config();
        logic [DATA_W-1:0] v;
        logic [STEP_W-1:0] dt;
        case ($urandom_range(0, 5))
            0:       v = S32_MIN;
            1:       v = S32_MAX;
            2:       v = '0;
            3:       v = REYNOLDS_RST;
            4:       v = int'($urandom_range(0, 128 << FRAC_W)) - (64 << FRAC_W);
            default: v = $urandom;
        endcase
        write_reg(REG_REYNOLDS, v);
        case ($urandom_range(0, 5))
            0:       dt = '0;
            1:       dt = STEP_RST;
            2:       dt = 21'd1 << FRAC_W;
            3:       dt = '1;
            4:       dt = STEP_W'($urandom_range(0, 32768));
            default: dt = STEP_W'($urandom);
        endcase
        v = $urandom;
        write_reg(REG_STEP_SIZE, {v[DATA_W-1:STEP_W], dt});
        for (int k = 0; k < NUM_MODES; k++)
            write_reg(cfg_reg_t'(REG_INIT_X1 + k), pick_mode_value());
        v = $urandom;
        write_reg(REG_EMIT_ON_WRITE, v);
    endtask

    // result side: check every accepted beat, stall at random
    initial
    begin
        int stall;
        stall         = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
            if (stall > 0)
            begin
                stall--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                stall = gap_len(rx_gaps);
                m_axis_tready <= (stall == 0);
            end
        end
    end

    // stimulus
    initial
    begin
        int r;
        sb            = new();
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        tx_gaps       = 1'b1;
        rx_gaps       = 1'b1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: plain trajectory from 1.0 with the stock drive
        send_beat(CMD_TICK, '0, '0);
        send_beat(CMD_TICK, 3'd7, '1);
        send_beat(CMD_TICK, '0, '0);
        // unused command is dropped
        send_beat(CMD_UNUSED, 3'd5, $urandom);
        // writes with emit off load quietly, the rails among them
        send_beat(CMD_WRITE, 3'd0, S32_MAX);
        send_beat(CMD_WRITE, 3'd1, S32_MIN);
        send_beat(CMD_WRITE, 3'd2, '0);
        send_beat(CMD_WRITE, 3'd3, '1);
        send_beat(CMD_WRITE, 3'd4, ONE_Q);
        // index beyond the last mode loads nothing
        send_beat(CMD_WRITE, 3'd5, $urandom);
        send_beat(CMD_WRITE, 3'd7, $urandom);
        // extreme modes force clipping in the derivatives
        send_beat(CMD_TICK, '0, '0);
        send_beat(CMD_TICK, '0, '0);
        send_beat(CMD_RESTORE, '0, '0);
        send_beat(CMD_TICK, '0, '0);

        // rails in every register, dt of exactly 1.0, emit on write
        settle();
        write_reg(REG_REYNOLDS, S32_MIN);
        write_reg(REG_STEP_SIZE, {11'h7FF, 21'd1 << FRAC_W});
        write_reg(REG_INIT_X1, S32_MAX);
        write_reg(REG_INIT_X2, S32_MIN);
        write_reg(REG_INIT_X3, '0);
        write_reg(REG_INIT_X4, '1);
        write_reg(REG_INIT_X5, ONE_Q);
        write_reg(REG_EMIT_ON_WRITE, '1);
        send_beat(CMD_RESTORE, '0, '0);
        send_beat(CMD_TICK, '0, '0);
        send_beat(CMD_WRITE, 3'd2, S32_MAX);
        // bad index still emits and steps when emit on write is set
        send_beat(CMD_WRITE, 3'd6, $urandom);
        send_beat(CMD_RESTORE, '0, '0);

        // step size above 1.0
        settle();
        write_reg(REG_REYNOLDS, S32_MAX);
        write_reg(REG_STEP_SIZE, 32'h001F_FFFF);
        send_beat(CMD_TICK, '0, '0);
        send_beat(CMD_TICK, '0, '0);

        // zero step: modes must hold
        settle();
        write_reg(REG_STEP_SIZE, {11'h000, 21'd0});
        send_beat(CMD_TICK, '0, '0);
        send_beat(CMD_TICK, '0, '0);

        // random phases: restore, then mostly ticks with writes and noise mixed in
        for (int phase = 0; phase < 8; phase++)
        begin
            settle();
            tx_gaps = (phase % 3 != 0);
            rx_gaps = (phase % 4 != 1);
            random_config();
            send_beat(CMD_RESTORE, VIDX_W'($urandom), $urandom);
            for (int n = 0; n < 54; n++)
            begin
                // sender holds off until the result side has caught up
                if (n == 27 && phase % 2 == 1)
                begin
                    s_axis_tvalid <= 1'b0;
                    while (sb.outstanding() != 0)
                        @(posedge clk);
                    @(posedge clk);
                end
                r = $urandom_range(0, 99);
                if (r < 68)
                    send_beat(CMD_TICK, VIDX_W'($urandom), $urandom);
                else if (r < 80)
                    send_beat(CMD_WRITE, VIDX_W'($urandom_range(0, NUM_MODES - 1)),
                              pick_mode_value());
                else if (r < 87)
                    send_beat(CMD_RESTORE, VIDX_W'($urandom), $urandom);
                else if (r < 92)
                    send_beat(CMD_UNUSED, VIDX_W'($urandom), $urandom);
                else
                    send_beat(CMD_WRITE, VIDX_W'($urandom_range(NUM_MODES, 7)), $urandom);
            end
        end

        // drain and let the block go quiet before the verdict
        s_axis_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (sb.failures == 0 && sb.outstanding() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #4_000_000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule
